/* src/color_contrast_ratio_grader_top_assert.svh */
// ----------------------------------------------------------------------------
// Contrast ratio grader assertion macros
// Shared property forms for the grader's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef COLOR_CONTRAST_RATIO_GRADER_TOP_ASSERT_SVH
`define COLOR_CONTRAST_RATIO_GRADER_TOP_ASSERT_SVH

// Same-cycle implication under reset.
`define CCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define CCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ccr_pkg.sv */
// ----------------------------------------------------------------------------
// Contrast ratio grader package
// Word types, fixed-point widths, grading codes and the sRGB linearization ROM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccr_pkg;

    localparam int LUM_FRAC_BITS = 16;

    localparam int CHAN_W   = 8;
    localparam int LIN_W    = 16;
    localparam int WEIGHT_W = 16;
    localparam int PROD_W   = LIN_W + WEIGHT_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int ROUND_SH = PROD_W - LUM_FRAC_BITS;
    localparam int LUM_W    = LUM_FRAC_BITS;
    localparam int DEN_W    = LUM_W + 1;
    localparam int NUM_W    = LUM_W + 10;
    localparam int QUOT_W   = 13;
    localparam int DIV_W    = DEN_W + QUOT_W;
    localparam int RATIO_W  = 13;
    localparam int FONT_W   = 8;

    localparam logic [WEIGHT_W-1:0] W_RED   = 16'd13933;
    localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd46871;
    localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd4732;

    localparam logic [LUM_W-1:0] LUM_OFFSET =
        LUM_W'(((64'd5 << LUM_FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [LUM_W-1:0] LUM_HALF = LUM_W'(64'd1 << (LUM_FRAC_BITS - 1));
    localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'(64'd1 << (ROUND_SH - 1));

    localparam logic [RATIO_W-1:0] RATIO_MAX  = 13'd5376;
    localparam logic [RATIO_W-1:0] RATIO_MIN  = 13'd256;
    localparam logic [RATIO_W-1:0] TH_PERFECT = 13'd1792;
    localparam logic [RATIO_W-1:0] TH_GOOD    = 13'd1152;
    localparam logic [RATIO_W-1:0] TH_LARGE   = 13'd768;

    localparam logic [FONT_W-1:0] FONT_RESET     = 8'd12;
    localparam logic [FONT_W-1:0] FONT_LARGE_PX  = 8'd18;
    localparam logic [FONT_W-1:0] FONT_MEDIUM_PX = 8'd14;

    typedef enum logic [1:0] {
        GRADE_BAD     = 2'd0,
        GRADE_GOOD    = 2'd1,
        GRADE_PERFECT = 2'd2
    } grade_t;

    typedef enum logic [1:0] {
        DISP_KEEP  = 2'd0,
        DISP_BLACK = 2'd1,
        DISP_WHITE = 2'd2
    } disp_t;

    typedef struct packed {
        logic [CHAN_W-1:0] fg_red;
        logic [CHAN_W-1:0] fg_green;
        logic [CHAN_W-1:0] fg_blue;
        logic [CHAN_W-1:0] bg_red;
        logic [CHAN_W-1:0] bg_green;
        logic [CHAN_W-1:0] bg_blue;
    } pair_word_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_q5_8;
        logic [1:0]         small_grade;
        logic [1:0]         medium_grade;
        logic [1:0]         large_grade;
        logic [1:0]         font_grade;
        logic [1:0]         display_choice;
    } grade_word_t;

    typedef struct packed {
        logic lb_high;
    } div_side_t;

    typedef logic [255:0][LIN_W-1:0] lin_rom_t;

    function automatic lin_rom_t build_lin_rom();
        lin_rom_t   rom;
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        for (int i = 0; i < 256; i++)
        begin
            c = 64'(i);
            if (c * 64'd100000 <= 64'd3928 * 64'd255)
            begin
                v = (c * 64'd6553600 + 64'd164730) / 64'd329460;
            end
            else
            begin
                x = ((64'd1000 * c + 64'd14025) << 32) / 64'd269025;
                if (x > 64'hFFFF_FFFF)
                begin
                    x = 64'hFFFF_FFFF;
                end
                x2 = (x * x) >> 32;
                r  = 64'd0;
                for (int b = 31; b >= 0; b--)
                begin
                    cand = r | (64'd1 << b);
                    p2   = (cand * cand) >> 32;
                    p4   = (p2 * p2) >> 32;
                    p5   = (p4 * cand) >> 32;
                    if (p5 <= x2)
                    begin
                        r = cand;
                    end
                end
                v = (((x2 * r) >> 32) + 64'd32768) >> 16;
            end
            if (v > 64'd65535)
            begin
                v = 64'd65535;
            end
            rom[i] = v[LIN_W-1:0];
        end
        return rom;
    endfunction

    localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

/* src/ccr_div.sv */
// ----------------------------------------------------------------------------
// Contrast ratio divider
// Restoring divider, one quotient bit per register stage, with bubble collapse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_div
    import ccr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_en,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  div_side_t         side,
    output logic              out_valid,
    input  logic              out_en,
    output logic [QUOT_W-1:0] quot,
    output div_side_t         out_side
);

    logic [QUOT_W-1:0]             valid_reg;
    logic [QUOT_W-1:0][NUM_W-1:0]  rem_reg;
    logic [QUOT_W-1:0][NUM_W-1:0]  rem_next;
    logic [QUOT_W-1:0][DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0][QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0][QUOT_W-1:0] quot_next;
    div_side_t [QUOT_W-1:0]        side_reg;
    logic [QUOT_W:0]               en;

    always_comb
    begin
        en[QUOT_W] = out_en;
        for (int k = QUOT_W - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_en = en[0];

    for (genvar k = 0; k < QUOT_W; k++)
    begin : g_stage
        localparam int BIT = QUOT_W - 1 - k;

        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] quot_in;
        logic              valid_in;
        div_side_t         side_in;
        logic [DIV_W-1:0]  dshift;
        logic [DIV_W-1:0]  rext;

        if (k == 0)
        begin : g_first
            assign rem_in   = num;
            assign den_in   = den;
            assign quot_in  = '0;
            assign valid_in = in_valid;
            assign side_in  = side;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign quot_in  = quot_reg[k-1];
            assign valid_in = valid_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        assign dshift = DIV_W'(den_in) << BIT;
        assign rext   = DIV_W'(rem_in);

        always_comb
        begin
            rem_next[k]  = rem_in;
            quot_next[k] = quot_in;
            if (rext >= dshift)
            begin
                rem_next[k]       = NUM_W'(rext - dshift);
                quot_next[k][BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_in;
                quot_reg[k] <= quot_next[k];
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quot      = quot_reg[QUOT_W-1];
    assign out_side  = side_reg[QUOT_W-1];

endmodule

/* src/color_contrast_ratio_grader_top.sv */
// ----------------------------------------------------------------------------
// Contrast ratio grader top level
// WCAG 2.0 contrast ratio of a text/background pair, graded for text sizes.
// ----------------------------------------------------------------------------
// Takes one colour pair per cycle while pair_stall is low and returns one
// grade word per pair, in order, through these stages in turn:
// ROM lookup, weighting multiply, luminance sum, min/max and operand setup,
// 13 divider stages (one quotient bit each) and the grading register. The
// divider pipeline holds most of the stages; throughput is one pair per cycle
// while grade_stall is low. Empty stages close up under output stall, so
// pair_stall rises only when every stage holds a word. The font size register
// is written through cfg_valid and is always ready.
`timescale 1ns / 1ps

module color_contrast_ratio_grader_top
    import ccr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_stall,
    input  pair_word_t        pair,
    output logic              grade_valid,
    input  logic              grade_stall,
    output grade_word_t       grade,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [FONT_W-1:0] cfg_data
);

    `include "color_contrast_ratio_grader_top_assert.svh"

    logic [FONT_W-1:0] font_size_reg;

    logic                       v1_reg;
    logic [5:0][LIN_W-1:0]      lin_reg;
    logic [5:0][LIN_W-1:0]      lin_next;
    logic                       v2_reg;
    logic [5:0][PROD_W-1:0]     prod_reg;
    logic [5:0][PROD_W-1:0]     prod_next;
    logic                       v3_reg;
    logic [LUM_W-1:0]           lf_reg;
    logic [LUM_W-1:0]           lb_reg;
    logic [LUM_W-1:0]           lf_next;
    logic [LUM_W-1:0]           lb_next;
    logic                       v4_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [NUM_W-1:0]           num_next;
    logic [DEN_W-1:0]           den_reg;
    logic [DEN_W-1:0]           den_next;
    div_side_t                  side_reg;
    div_side_t                  side_next;
    logic                       vout_reg;
    grade_word_t                grade_reg;
    grade_word_t                grade_next;

    logic [SUM_W-1:0]  sum_f;
    logic [SUM_W-1:0]  sum_b;
    logic [LUM_W-1:0]  lmax;
    logic [LUM_W-1:0]  lmin;
    logic [RATIO_W-1:0] ratio;
    grade_t            gs;
    grade_t            gm;
    grade_t            gl;
    grade_t            gf;
    disp_t             disp;

    logic              en1;
    logic              en2;
    logic              en3;
    logic              en4;
    logic              div_en;
    logic              out_en;
    logic              div_valid;
    logic [QUOT_W-1:0] div_quot;
    div_side_t         div_side;

    // stall chain: a stage loads when it is empty or its successor loads
    assign out_en     = !vout_reg || !grade_stall;
    assign en4        = !v4_reg || div_en;
    assign en3        = !v3_reg || en4;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign pair_stall = !en1;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_size_reg <= FONT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            font_size_reg <= cfg_data;
        end
    end

    always_comb
    begin
        lin_next[0] = LIN_ROM[pair.fg_red];
        lin_next[1] = LIN_ROM[pair.fg_green];
        lin_next[2] = LIN_ROM[pair.fg_blue];
        lin_next[3] = LIN_ROM[pair.bg_red];
        lin_next[4] = LIN_ROM[pair.bg_green];
        lin_next[5] = LIN_ROM[pair.bg_blue];
    end

    always_comb
    begin
        prod_next[0] = lin_reg[0] * W_RED;
        prod_next[1] = lin_reg[1] * W_GREEN;
        prod_next[2] = lin_reg[2] * W_BLUE;
        prod_next[3] = lin_reg[3] * W_RED;
        prod_next[4] = lin_reg[4] * W_GREEN;
        prod_next[5] = lin_reg[5] * W_BLUE;
    end

    always_comb
    begin
        sum_f   = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                + ROUND_ADD;
        sum_b   = SUM_W'(prod_reg[3]) + SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5])
                + ROUND_ADD;
        lf_next = sum_f[ROUND_SH +: LUM_W];
        lb_next = sum_b[ROUND_SH +: LUM_W];
    end

    always_comb
    begin
        if (lf_reg > lb_reg)
        begin
            lmax = lf_reg;
            lmin = lb_reg;
        end
        else
        begin
            lmax = lb_reg;
            lmin = lf_reg;
        end
        den_next          = DEN_W'(lmin) + DEN_W'(LUM_OFFSET);
        num_next          = (NUM_W'(DEN_W'(lmax) + DEN_W'(LUM_OFFSET)) << 8)
                          + NUM_W'(den_next >> 1);
        side_next.lb_high = lb_reg > LUM_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pair_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (out_en)
            begin
                vout_reg <= div_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            lin_reg <= lin_next;
        end
        if (en2)
        begin
            prod_reg <= prod_next;
        end
        if (en3)
        begin
            lf_reg <= lf_next;
            lb_reg <= lb_next;
        end
        if (en4)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
        if (out_en)
        begin
            grade_reg <= grade_next;
        end
    end

    ccr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_en     (div_en),
        .num       (num_reg),
        .den       (den_reg),
        .side      (side_reg),
        .out_valid (div_valid),
        .out_en    (out_en),
        .quot      (div_quot),
        .out_side  (div_side)
    );

    always_comb
    begin
        ratio = (div_quot > RATIO_MAX) ? RATIO_MAX : div_quot;

        priority if (ratio > TH_PERFECT)
        begin
            gs = GRADE_PERFECT;
            gm = GRADE_PERFECT;
            gl = GRADE_PERFECT;
        end
        else if (ratio > TH_GOOD)
        begin
            gs = GRADE_GOOD;
            gm = GRADE_GOOD;
            gl = GRADE_PERFECT;
        end
        else if (ratio > TH_LARGE)
        begin
            gs = GRADE_BAD;
            gm = GRADE_BAD;
            gl = GRADE_GOOD;
        end
        else
        begin
            gs = GRADE_BAD;
            gm = GRADE_BAD;
            gl = GRADE_BAD;
        end

        priority if (font_size_reg >= FONT_LARGE_PX)
        begin
            gf = gl;
        end
        else if (font_size_reg >= FONT_MEDIUM_PX)
        begin
            gf = gm;
        end
        else
        begin
            gf = gs;
        end

        priority if (ratio > TH_LARGE)
        begin
            disp = DISP_KEEP;
        end
        else if (div_side.lb_high)
        begin
            disp = DISP_BLACK;
        end
        else
        begin
            disp = DISP_WHITE;
        end

        grade_next.ratio_q5_8     = ratio;
        grade_next.small_grade    = gs;
        grade_next.medium_grade   = gm;
        grade_next.large_grade    = gl;
        grade_next.font_grade     = gf;
        grade_next.display_choice = disp;
    end

    assign grade_valid = vout_reg;
    assign grade       = grade_reg;

    `CCR_ASSERT_NOW(a_ratio_range, grade_valid,
        grade.ratio_q5_8 >= RATIO_MIN && grade.ratio_q5_8 <= RATIO_MAX,
        "ratio out of range")
    `CCR_ASSERT_NOW(a_disp_low_contrast, grade_valid && grade.display_choice != DISP_KEEP,
        grade.large_grade == GRADE_BAD && grade.font_grade == GRADE_BAD,
        "display colour change with passing contrast")
    `CCR_ASSERT_NEXT(a_div_hold, div_valid && !out_en,
        div_valid && $stable(div_quot) && $stable(div_side),
        "divider output lost under stall")
    `CCR_ASSERT_NEXT(a_font_write, cfg_valid && cfg_ready,
        font_size_reg == $past(cfg_data),
        "font size write not taken")

endmodule
